FILE: rtl/core/wpf8_pkg.sv
// ----------------------------------------------------------------------------
// wpf8_pkg
// Shared widths, register indexes and types of the word packet framer with
// 8-bit Fletcher checksum.
// ----------------------------------------------------------------------------
package wpf8_pkg;

  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 16;
  localparam int COUNT_W     = 7;
  localparam int CFG_INDEX_W = 8;
  localparam int MAX_BYTES   = 6;
  localparam int FILL_W      = $clog2(MAX_BYTES + 1);

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_WORDS = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_MESSAGE_TYPE  = CFG_INDEX_W'(1);

  localparam logic [COUNT_W-1:0] PAYLOAD_WORDS_RESET = COUNT_W'(1);
  localparam logic [BYTE_W-1:0]  MESSAGE_TYPE_RESET  = BYTE_W'(1);

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [FILL_W-1:0]  fill_t;

endpackage

FILE: rtl/core/word_packet_framer_fletcher8_core.sv
// ----------------------------------------------------------------------------
// word_packet_framer_fletcher8_core
// Turns 16-bit words into byte frames: type, length, payload (high byte
// first), then Fletcher-8 sums A and B over length and payload.
// ----------------------------------------------------------------------------
// Each accepted word is expanded combinationally into its frame bytes (two,
// plus two header bytes on the first word of a frame, plus two checksum bytes
// on the last) held in a six-byte output buffer, which then drains one byte
// per cycle on the master side while m_tready is high. A new word is taken
// while the final byte of the previous one is being handed over, so the bytes
// of consecutive words follow with no gap; a word has 2 bytes in the middle
// of a frame and 4 or 6 at its edges. The configuration port is always ready;
// payload_words of zero acts as one, and the length byte keeps the count seen
// at the frame's first word.
module word_packet_framer_fletcher8_core (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wpf8_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wpf8_pkg::BYTE_W-1:0]     cfg_data,
  // input words
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [wpf8_pkg::WORD_W-1:0]     s_tdata,   // [15:0] data_word
  // output bytes
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [wpf8_pkg::BYTE_W-1:0]     m_tdata,   // [7:0] frame_byte
  output logic                            m_tuser,   // [0] item_done
  output logic                            m_tlast    // frame_done
);

  // configuration and frame state
  wpf8_pkg::count_t payload_words;
  wpf8_pkg::byte_t  message_type;
  wpf8_pkg::count_t words_sent;
  wpf8_pkg::byte_t  sum_a;
  wpf8_pkg::byte_t  sum_b;

  // output buffer
  wpf8_pkg::byte_t  obuf [wpf8_pkg::MAX_BYTES];
  wpf8_pkg::fill_t  remaining;
  logic             frame_flag;

  // item expansion
  wpf8_pkg::count_t eff_count;
  wpf8_pkg::count_t ws_inc;
  wpf8_pkg::byte_t  len_byte, hi, lo;
  wpf8_pkg::byte_t  a0, b0, a1, b1, a2, b2;
  wpf8_pkg::byte_t  item_bytes [wpf8_pkg::MAX_BYTES];
  wpf8_pkg::fill_t  item_len;
  logic             first, last;
  logic             in_take, out_take;

  assign cfg_ready = 1'b1;

  assign m_tvalid = (remaining != '0);
  assign m_tdata  = obuf[0];
  assign m_tuser  = (remaining == wpf8_pkg::FILL_W'(1));
  assign m_tlast  = m_tuser && frame_flag;

  assign out_take = m_tvalid && m_tready;
  // free, or the last byte of the buffer leaves this cycle
  assign s_tready = (remaining == '0) || (m_tuser && m_tready);
  assign in_take  = s_tvalid && s_tready;

  assign eff_count = (payload_words == '0) ? wpf8_pkg::COUNT_W'(1) : payload_words;
  assign first     = (words_sent == '0);
  assign ws_inc    = words_sent + wpf8_pkg::COUNT_W'(1);
  assign last      = (ws_inc >= eff_count);
  assign len_byte  = {eff_count, 1'b0};
  assign hi        = s_tdata[15:8];
  assign lo        = s_tdata[7:0];

  // running fletcher sums through the length byte and both payload bytes
  assign a0 = first ? len_byte : sum_a;
  assign b0 = first ? len_byte : sum_b;
  assign a1 = a0 + hi;
  assign b1 = b0 + a1;
  assign a2 = a1 + lo;
  assign b2 = b1 + a2;

  always_comb begin
    if (first) begin
      item_bytes[0] = message_type;
      item_bytes[1] = len_byte;
      item_bytes[2] = hi;
      item_bytes[3] = lo;
      item_bytes[4] = a2;
      item_bytes[5] = b2;
      item_len      = last ? wpf8_pkg::FILL_W'(6) : wpf8_pkg::FILL_W'(4);
    end else begin
      item_bytes[0] = hi;
      item_bytes[1] = lo;
      item_bytes[2] = a2;
      item_bytes[3] = b2;
      item_bytes[4] = '0;
      item_bytes[5] = '0;
      item_len      = last ? wpf8_pkg::FILL_W'(4) : wpf8_pkg::FILL_W'(2);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_words <= wpf8_pkg::PAYLOAD_WORDS_RESET;
      message_type  <= wpf8_pkg::MESSAGE_TYPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wpf8_pkg::REG_PAYLOAD_WORDS: payload_words <= cfg_data[wpf8_pkg::COUNT_W-1:0];
        wpf8_pkg::REG_MESSAGE_TYPE:  message_type  <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      words_sent <= '0;
      sum_a      <= '0;
      sum_b      <= '0;
    end else if (in_take) begin
      words_sent <= last ? '0 : ws_inc;
      sum_a      <= last ? '0 : a2;
      sum_b      <= last ? '0 : b2;
    end
  end

  // buffer fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (in_take) begin
      remaining <= item_len;
    end else if (out_take) begin
      remaining <= remaining - wpf8_pkg::FILL_W'(1);
    end
  end

  // buffer payload, shifts toward slot 0 as bytes leave
  always_ff @(posedge clk) begin
    if (in_take) begin
      for (int i = 0; i < wpf8_pkg::MAX_BYTES; i++) begin
        obuf[i] <= item_bytes[i];
      end
      frame_flag <= last;
    end else if (out_take) begin
      for (int i = 0; i < wpf8_pkg::MAX_BYTES - 1; i++) begin
        obuf[i] <= obuf[i + 1];
      end
    end
  end

  // checks
  a_tlast_ends_item: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser)
    else $error("frame close without item close");

  a_accept_shows_byte: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (m_tvalid && remaining >= wpf8_pkg::FILL_W'(2)))
    else $error("accepted word produced too few bytes");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    remaining <= wpf8_pkg::FILL_W'(wpf8_pkg::MAX_BYTES))
    else $error("output buffer overfilled");

  a_close_resets_count: assert property (@(posedge clk) disable iff (rst)
    (out_take && m_tlast) |-> (words_sent == '0))
    else $error("frame closed but word count not cleared");

endmodule

FILE: tb/sv/wpf8_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wpf8_frame_checker
// Watches the configuration, word and byte channels of the framer. It keeps
// its own copy of the registers, word position and Fletcher sums, expands
// every accepted word into the frame bytes it should produce, and compares
// each accepted output byte against the oldest expected one.
// ----------------------------------------------------------------------------
module wpf8_frame_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [wpf8_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wpf8_pkg::BYTE_W-1:0]      cfg_data,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [wpf8_pkg::WORD_W-1:0]      s_tdata,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [wpf8_pkg::BYTE_W-1:0]      m_tdata,
  input  logic                             m_tuser,
  input  logic                             m_tlast,
  output int                               fail_count,
  output int                               outstanding
);

  typedef struct packed {
    wpf8_pkg::byte_t value;
    logic            word_end;
    logic            frame_end;
  } wire_byte_t;

  wire_byte_t wire_bytes[$];

  wpf8_pkg::count_t cfg_count;
  wpf8_pkg::byte_t  cfg_type;
  wpf8_pkg::count_t frame_pos;
  wpf8_pkg::byte_t  fsum_a;
  wpf8_pkg::byte_t  fsum_b;
  int               bytes_seen;

  task automatic report_mismatch(string field, int got, int want);
    $display("%0t ns: byte %0d, %s: got %0h, want %0h", $time, bytes_seen, field, got, want);
    fail_count++;
  endtask

  function automatic void push_byte(wpf8_pkg::byte_t value, logic word_end, logic frame_end);
    wire_byte_t b;
    b.value     = value;
    b.word_end  = word_end;
    b.frame_end = frame_end;
    wire_bytes.push_back(b);
  endfunction

  function automatic void fold_sum(wpf8_pkg::byte_t b);
    fsum_a = fsum_a + b;
    fsum_b = fsum_b + fsum_a;
  endfunction

  // expand one word into its frame bytes and advance the frame state
  function automatic void frame_word(logic [wpf8_pkg::WORD_W-1:0] w);
    wpf8_pkg::count_t eff;
    wpf8_pkg::byte_t  len;
    logic             closes;
    eff = (cfg_count == '0) ? wpf8_pkg::count_t'(1) : cfg_count;
    if (frame_pos == '0) begin
      len    = {eff, 1'b0};
      fsum_a = '0;
      fsum_b = '0;
      push_byte(cfg_type, 1'b0, 1'b0);
      push_byte(len, 1'b0, 1'b0);
      fold_sum(len);
    end
    frame_pos = frame_pos + wpf8_pkg::count_t'(1);
    closes    = (frame_pos >= eff);
    fold_sum(w[15:8]);
    fold_sum(w[7:0]);
    push_byte(w[15:8], 1'b0, 1'b0);
    push_byte(w[7:0], !closes, 1'b0);
    if (closes) begin
      push_byte(fsum_a, 1'b0, 1'b0);
      push_byte(fsum_b, 1'b1, 1'b1);
      frame_pos = '0;
      fsum_a    = '0;
      fsum_b    = '0;
    end
  endfunction

  always @(posedge clk) begin : watch
    wire_byte_t want;
    if (rst) begin
      cfg_count  = wpf8_pkg::PAYLOAD_WORDS_RESET;
      cfg_type   = wpf8_pkg::MESSAGE_TYPE_RESET;
      frame_pos  = '0;
      fsum_a     = '0;
      fsum_b     = '0;
      bytes_seen = 0;
      wire_bytes.delete();
    end else begin
      // a word taken at the same edge as a write still sees the old registers
      if (s_tvalid && s_tready)
        frame_word(s_tdata);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wpf8_pkg::REG_PAYLOAD_WORDS: cfg_count = cfg_data[wpf8_pkg::COUNT_W-1:0];
          wpf8_pkg::REG_MESSAGE_TYPE:  cfg_type  = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (wire_bytes.size() == 0) begin
          report_mismatch("unexpected byte", m_tdata, 0);
        end else begin
          want = wire_bytes.pop_front();
          if (m_tdata !== want.value)
            report_mismatch("frame_byte", m_tdata, want.value);
          if (m_tuser !== want.word_end)
            report_mismatch("item_done", m_tuser, want.word_end);
          if (m_tlast !== want.frame_end)
            report_mismatch("frame_done", m_tlast, want.frame_end);
        end
        bytes_seen++;
      end
    end
    outstanding <= wire_bytes.size();
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the word packet framer: directed frames covering register
// extremes, masking, ignored writes and count or type changes mid-frame,
// then random phases of words with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;

  localparam int TOTAL_WORDS = 270;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [wpf8_pkg::CFG_INDEX_W-1:0] REG_SPARE = wpf8_pkg::CFG_INDEX_W'(2);
  localparam logic [wpf8_pkg::CFG_INDEX_W-1:0] REG_TOP   = wpf8_pkg::CFG_INDEX_W'(255);

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [wpf8_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [wpf8_pkg::BYTE_W-1:0]      cfg_data = '0;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [wpf8_pkg::WORD_W-1:0]      s_tdata = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [wpf8_pkg::BYTE_W-1:0]      m_tdata;
  logic                             m_tuser;
  logic                             m_tlast;

  int   fail_count;
  int   outstanding;
  int   cycle_count = 0;
  int   words_sent = 0;
  logic stall_en = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  word_packet_framer_fletcher8_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  wpf8_frame_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // byte sink backpressure
  always @(posedge clk) begin
    m_tready <= !stall_en || ($urandom_range(99) >= 27);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // cfg_valid drops after each write, which keeps back to back writes apart
  task automatic write_reg(logic [wpf8_pkg::CFG_INDEX_W-1:0] idx,
                           logic [wpf8_pkg::BYTE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_word(logic [wpf8_pkg::WORD_W-1:0] w);
    if (stall_en) begin
      while ($urandom_range(99) < 27) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  // sender holds off until every expected byte has been taken
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [wpf8_pkg::WORD_W-1:0] random_word();
    int r;
    r = $urandom_range(99);
    if (r < 5)
      return '0;
    else if (r < 10)
      return '1;
    return wpf8_pkg::WORD_W'($urandom_range(65535));
  endfunction

  initial begin : stimulus
    int          cnt;
    int          nwords;
    logic [7:0]  cnt_data;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset values: one word per frame, type 1
    send_word(16'h0000);
    send_word(16'hFFFF);

    // zero count acts as one once bit 7 is masked off
    wait_drained();
    write_reg(wpf8_pkg::REG_PAYLOAD_WORDS, 8'h80);
    write_reg(wpf8_pkg::REG_MESSAGE_TYPE, 8'hFF);
    send_word(16'h8001);
    send_word(16'h7FFE);

    // count lowered and type changed mid-frame
    wait_drained();
    write_reg(wpf8_pkg::REG_PAYLOAD_WORDS, 8'd3);
    write_reg(wpf8_pkg::REG_MESSAGE_TYPE, 8'h00);
    send_word(16'hA55A);
    send_word(16'h5AA5);
    wait_drained();
    write_reg(wpf8_pkg::REG_PAYLOAD_WORDS, 8'd1);
    write_reg(wpf8_pkg::REG_MESSAGE_TYPE, 8'h02);
    send_word(16'h1234);
    send_word(16'hFFFF);

    // writes outside the register map are dropped
    wait_drained();
    write_reg(REG_SPARE, 8'h55);
    write_reg(REG_TOP, 8'hAA);
    write_reg(wpf8_pkg::REG_PAYLOAD_WORDS, 8'hFF);
    send_word(16'h0001);
    send_word(16'h8000);
    wait_drained();
    write_reg(wpf8_pkg::REG_PAYLOAD_WORDS, 8'd2);
    send_word(16'h00FF);

    // count raised mid-frame
    send_word(16'hFF00);
    wait_drained();
    write_reg(wpf8_pkg::REG_PAYLOAD_WORDS, 8'd4);
    send_word(16'h3C3C);
    send_word(16'hC3C3);
    send_word(16'h0F0F);

    // longest frame with no stalls on either side
    wait_drained();
    write_reg(wpf8_pkg::REG_PAYLOAD_WORDS, 8'd127);
    stall_en = 1'b0;
    repeat (127) send_word(random_word());
    wait_drained();
    stall_en = 1'b1;

    while (words_sent < TOTAL_WORDS) begin
      wait_drained();
      case ($urandom_range(9))
        0:       cnt = 0;
        1:       cnt = $urandom_range(9, 40);
        default: cnt = $urandom_range(1, 6);
      endcase
      cnt_data = 8'(cnt) | 8'($urandom_range(1) << 7);
      write_reg(wpf8_pkg::REG_PAYLOAD_WORDS, cnt_data);
      if ($urandom_range(2) == 0)
        write_reg(wpf8_pkg::REG_MESSAGE_TYPE, 8'($urandom_range(255)));
      if (cnt == 0)
        cnt = 1;
      // mostly whole frames, sometimes left open for the next phase
      if ($urandom_range(3) == 0)
        nwords = $urandom_range(1, 2 * cnt);
      else
        nwords = cnt * $urandom_range(1, 3);
      if (nwords > TOTAL_WORDS - words_sent)
        nwords = TOTAL_WORDS - words_sent;
      repeat (nwords) send_word(random_word());
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/wpf8_pkg.sv
rtl/core/word_packet_framer_fletcher8_core.sv
tb/sv/wpf8_frame_checker.sv
tb/sv/tb.sv
